[hw/rtl/rev_id_text_to_binary_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the revision ID converter
// Concurrent assertion shorthands clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef REV_ID_TEXT_TO_BINARY_MACROS_SVH
`define REV_ID_TEXT_TO_BINARY_MACROS_SVH

// Plain property, checked at every clock edge outside reset.
`define RITB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define RITB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RITB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ritb_pkg.sv]
// ----------------------------------------------------------------------------
// Revision ID converter package
// Widths, character codes and the command type passed from front to back.
// ----------------------------------------------------------------------------
package ritb_pkg;

  localparam int unsigned MaxGenDigits = 8;

  localparam int unsigned CharW  = 8;
  localparam int unsigned GenW   = 27;
  localparam int unsigned CntW   = 4;
  localparam int unsigned CapW   = 7;
  localparam int unsigned NbW    = 3;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [CapW-1:0] CapReset = 7'd42;

  localparam logic [CharW-1:0] CharDash  = 8'h2D;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharLowA  = 8'h61;
  localparam logic [CharW-1:0] CharLowF  = 8'h66;
  localparam logic [CharW-1:0] CharUpA   = 8'h41;
  localparam logic [CharW-1:0] CharUpF   = 8'h46;

  localparam logic [AddrW-1:0] RegCapacity = 3'd0;

  typedef struct packed {
    logic [GenW-1:0] data;
    logic [NbW-1:0]  nbytes;
    logic            raw;
    logic            done;
    logic            status;
  } ritb_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ritb_qstat_t;

endpackage

[hw/rtl/ritb_front.sv]
// ----------------------------------------------------------------------------
// Revision ID converter front end
// Parses one character per beat and queues byte and done commands.
// ----------------------------------------------------------------------------
module ritb_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [ritb_pkg::CharW-1:0] char_i,
  input  logic                      last_i,
  input  logic                      fire_i,
  input  logic [ritb_pkg::CapW-1:0] capacity_i,
  output ritb_pkg::ritb_cmd_t       cmd_o,
  output logic                      push_o
);
  import ritb_pkg::*;

  typedef enum logic {PhGen, PhDigest} phase_e;

  phase_e            phase_q, phase_d;
  logic [GenW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [3:0]        high_q, high_d;
  logic              pend_q, pend_d;
  logic [CapW-1:0]   bytes_q, bytes_d;
  logic              fail_q, fail_d;

  logic              is_digit;
  logic [3:0]        digit;
  logic              hex_ok;
  logic [3:0]        hex_val;
  logic [NbW-1:0]    n_var;
  logic [NbW-1:0]    n_emit;
  logic [CharW-1:0]  hex_off;

  always_comb begin
    is_digit = (char_i >= CharZero) && (char_i <= CharNine);
    digit    = 4'(char_i - CharZero);
    hex_off  = '0;
    hex_ok   = 1'b1;
    if (is_digit) begin
      hex_off = char_i - CharZero;
    end else if ((char_i >= CharLowA) && (char_i <= CharLowF)) begin
      hex_off = char_i - CharLowA + 8'd10;
    end else if ((char_i >= CharUpA) && (char_i <= CharUpF)) begin
      hex_off = char_i - CharUpA + 8'd10;
    end else begin
      hex_ok = 1'b0;
    end
    hex_val = hex_off[3:0];

    n_var = 3'd1 + NbW'(acc_q >= GenW'(1 << 7)) + NbW'(acc_q >= GenW'(1 << 14))
          + NbW'(acc_q >= GenW'(1 << 21));
    n_emit = (capacity_i < CapW'(n_var)) ? capacity_i[NbW-1:0] : n_var;
  end

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    high_d  = high_q;
    pend_d  = pend_q;
    bytes_d = bytes_q;
    fail_d  = fail_q;
    cmd_o   = '0;

    if (!fail_q) begin
      if (phase_q == PhGen) begin
        if (char_i == CharDash) begin
          if ((cnt_q == '0) || (acc_q == '0) || last_i) begin
            fail_d = 1'b1;
          end else begin
            phase_d      = PhDigest;
            cmd_o.data   = acc_q;
            cmd_o.nbytes = n_emit;
            bytes_d      = CapW'(n_emit);
            if (capacity_i < CapW'(n_var)) begin
              fail_d = 1'b1;
            end
          end
        end else if (is_digit) begin
          if (cnt_q >= CntW'(MaxGenDigits)) begin
            fail_d = 1'b1;
          end else begin
            acc_d = (acc_q << 3) + (acc_q << 1) + GenW'(digit);
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          fail_d = 1'b1;
        end
        if (last_i && (phase_d == PhGen)) begin
          fail_d = 1'b1;
        end
      end else begin
        if (!hex_ok) begin
          fail_d = 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
          if (bytes_q < capacity_i) begin
            cmd_o.nbytes = NbW'(1);
            cmd_o.raw    = 1'b1;
            cmd_o.data   = GenW'({high_q, hex_val});
            bytes_d      = bytes_q + 1'b1;
          end else begin
            fail_d = 1'b1;
          end
        end else begin
          high_d = hex_val;
          pend_d = 1'b1;
        end
        if (last_i && pend_d) begin
          fail_d = 1'b1;
        end
      end
    end

    if (last_i) begin
      cmd_o.done   = 1'b1;
      cmd_o.status = fail_d;
      phase_d      = PhGen;
      acc_d        = '0;
      cnt_d        = '0;
      high_d       = '0;
      pend_d       = 1'b0;
      bytes_d      = '0;
      fail_d       = 1'b0;
    end
  end

  assign push_o = fire_i && ((cmd_o.nbytes != '0) || last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhGen;
      acc_q   <= '0;
      cnt_q   <= '0;
      high_q  <= '0;
      pend_q  <= 1'b0;
      bytes_q <= '0;
      fail_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      high_q  <= high_d;
      pend_q  <= pend_d;
      bytes_q <= bytes_d;
      fail_q  <= fail_d;
    end
  end

endmodule

[hw/rtl/ritb_queue.sv]
// ----------------------------------------------------------------------------
// Revision ID converter command queue
// Short register FIFO that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
module ritb_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ritb_pkg::ritb_cmd_t    cmd_i,
  input  logic                   pop_i,
  output ritb_pkg::ritb_cmd_t    cmd_o,
  output ritb_pkg::ritb_qstat_t  stat_o
);
  import ritb_pkg::*;

  ritb_cmd_t         mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QCntW-1:0]  cnt_q;

  assign cmd_o        = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/ritb_back.sv]
// ----------------------------------------------------------------------------
// Revision ID converter back end
// Expands queued commands into result beats, one beat per cycle while the consumer is ready.
// ----------------------------------------------------------------------------
module ritb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ritb_pkg::ritb_cmd_t   cmd_i,
  input  ritb_pkg::ritb_qstat_t stat_i,
  output logic                  pop_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [7:0]            byte_o,
  output logic                  byte_valid_o,
  output logic                  done_o,
  output logic                  status_o
);
  import ritb_pkg::*;

  ritb_cmd_t        cmd_q;
  logic             valid_q;
  logic [NbW-1:0]   idx_q;

  logic [NbW-1:0]   total;
  logic             last_res;
  logic             is_byte;
  logic [GenW:0]    data_ext;
  logic [6:0]       group;
  logic             more;

  // A varint byte carries the continuation bit whenever higher groups remain,
  // even when the capacity cuts the varint short.
  always_comb begin
    total    = cmd_q.nbytes + NbW'(cmd_q.done);
    last_res = (idx_q == total - 1'b1);
    is_byte  = (idx_q < cmd_q.nbytes);
    data_ext = {1'b0, cmd_q.data};
    unique case (idx_q[1:0])
      2'd0: begin
        group = data_ext[6:0];
        more  = |data_ext[GenW:7];
      end
      2'd1: begin
        group = data_ext[13:7];
        more  = |data_ext[GenW:14];
      end
      2'd2: begin
        group = data_ext[20:14];
        more  = |data_ext[GenW:21];
      end
      default: begin
        group = data_ext[27:21];
        more  = 1'b0;
      end
    endcase
    if (!is_byte) begin
      byte_o = '0;
    end else if (cmd_q.raw) begin
      byte_o = cmd_q.data[7:0];
    end else begin
      byte_o = {more, group};
    end
  end

  assign valid_o      = valid_q;
  assign byte_valid_o = is_byte;
  assign done_o       = !is_byte;
  assign status_o     = !is_byte && cmd_q.status;
  assign pop_o        = !stat_i.empty && (!valid_q || (ready_i && last_res));

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (valid_q && ready_i) begin
      if (last_res) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

endmodule

[hw/rtl/rev_id_text_to_binary.sv]
// ----------------------------------------------------------------------------
// Text revision ID to binary converter
// Turns "generation-hexdigest" text into a varint generation and digest bytes.
// ----------------------------------------------------------------------------
// The block takes one character per cycle as long as its four-entry command
// queue has room, and gives one result beat per cycle while the consumer is
// ready. A dash after the generation yields up to four varint beats, every
// second digest character yields one byte beat, and the final character yields
// a done beat with the status; the output stage, one beat per cycle, sets the
// sustained rate when results outnumber characters. On a bad status the
// consumer drops every byte of that ID.
module rev_id_text_to_binary (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] char_in
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // [7:0] out_byte
  output logic [1:0]                   m_axis_tuser,  // [0] byte_valid, [1] status
  output logic                         m_axis_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ritb_pkg::AddrW-1:0]   paddr,
  input  logic [ritb_pkg::DataW-1:0]   pwdata,
  output logic [ritb_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  import ritb_pkg::*;

  logic [CapW-1:0] cap_q;
  logic            fire;
  logic            push;
  logic            pop;
  ritb_cmd_t       front_cmd;
  ritb_cmd_t       head_cmd;
  ritb_qstat_t     qstat;
  logic            res_byte_valid;
  logic            res_status;
  logic            reg_sel;

  assign pready        = 1'b1;
  assign reg_sel       = (paddr[AddrW-1] == RegCapacity[AddrW-1]);
  assign prdata        = reg_sel ? DataW'(cap_q) : '0;
  assign s_axis_tready = !qstat.full;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign m_axis_tuser  = {res_status, res_byte_valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      cap_q <= pwdata[CapW-1:0];
    end
  end

  ritb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_i     (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .fire_i     (fire),
    .capacity_i (cap_q),
    .cmd_o      (front_cmd),
    .push_o     (push)
  );

  ritb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (qstat)
  );

  ritb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (head_cmd),
    .stat_i       (qstat),
    .pop_o        (pop),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .byte_o       (m_axis_tdata),
    .byte_valid_o (res_byte_valid),
    .done_o       (m_axis_tlast),
    .status_o     (res_status)
  );

`include "rev_id_text_to_binary_macros.svh"

  `RITB_ASSERT_IMPL(a_byte_not_done, m_axis_tvalid && res_byte_valid, !m_axis_tlast, "byte beat marked done")
  `RITB_ASSERT_IMPL(a_status_on_done, m_axis_tvalid && !m_axis_tlast, !res_status, "status set on a data beat")
  `RITB_ASSERT_IMPL(a_no_push_full, qstat.full, !push, "push into a full queue")
  `RITB_ASSERT_NEXT(a_pop_gives_valid, pop, m_axis_tvalid, "popped command not presented")

endmodule

[dv/rev_id_text_to_binary_checker.sv]
// ----------------------------------------------------------------------------
// Revision ID converter checker
// Watches the character, result and register ports, predicts every result
// beat of each text revision ID and compares the beats in order.
// ----------------------------------------------------------------------------
module rev_id_text_to_binary_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [7:0] char_in
  input  logic                       s_axis_tlast,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [7:0]                 m_axis_tdata,  // [7:0] out_byte
  input  logic [1:0]                 m_axis_tuser,  // [0] byte_valid, [1] status
  input  logic                       m_axis_tlast,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ritb_pkg::AddrW-1:0] paddr,
  input  logic [ritb_pkg::DataW-1:0] pwdata,
  input  logic [ritb_pkg::DataW-1:0] prdata,
  input  logic                       pready,
  output int                         mismatches_o,
  output int                         beats_due_o
);
  import ritb_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       done;
    logic       status;
  } id_beat_t;

  id_beat_t        beats_due[$];
  id_beat_t        want;
  logic [CapW-1:0] cap_q;
  logic            in_digest;
  logic [GenW-1:0] gen_acc;
  logic [CntW-1:0] digit_cnt;
  logic [3:0]      hi_nib;
  logic            nib_pend;
  logic [CapW-1:0] bytes_sent;
  logic            id_failed;
  int              errors;

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
    $display("mismatch at %0t: %s is %0h, expected %0h", $time, what, got, exp_val);
    errors++;
  endtask

  task automatic clear_id();
    in_digest  = 1'b0;
    gen_acc    = '0;
    digit_cnt  = '0;
    hi_nib     = '0;
    nib_pend   = 1'b0;
    bytes_sent = '0;
    id_failed  = 1'b0;
  endtask

  function automatic int hex_nibble(input logic [7:0] ch);
    if (ch >= CharZero && ch <= CharNine) return int'(ch - CharZero);
    if (ch >= CharLowA && ch <= CharLowF) return int'(ch - CharLowA) + 10;
    if (ch >= CharUpA && ch <= CharUpF) return int'(ch - CharUpA) + 10;
    return -1;
  endfunction

  // A byte that would go past the capacity is dropped and fails the ID.
  task automatic emit_byte(input logic [7:0] b);
    if (bytes_sent >= cap_q) begin
      id_failed = 1'b1;
    end else begin
      bytes_sent = bytes_sent + 1'b1;
      beats_due.push_back('{data: b, valid: 1'b1, done: 1'b0, status: 1'b0});
    end
  endtask

  task automatic decode_char(input logic [7:0] ch, input logic fin);
    logic [27:0] g;
    int          h;
    if (!id_failed) begin
      if (!in_digest) begin
        if (ch == CharDash) begin
          if (digit_cnt == 0 || gen_acc == 0 || fin) begin
            id_failed = 1'b1;
          end else begin
            g = 28'(gen_acc);
            in_digest = 1'b1;
            while (g >= 28'd128 && !id_failed) begin
              emit_byte({1'b1, g[6:0]});
              g = g >> 7;
            end
            if (!id_failed) emit_byte(g[7:0]);
          end
        end else if (ch >= CharZero && ch <= CharNine) begin
          if (digit_cnt >= MaxGenDigits) begin
            id_failed = 1'b1;
          end else begin
            gen_acc = GenW'(gen_acc * 10 + (ch - CharZero));
            digit_cnt = digit_cnt + 1'b1;
          end
        end else begin
          id_failed = 1'b1;
        end
        if (fin && !in_digest) id_failed = 1'b1;
      end else begin
        h = hex_nibble(ch);
        if (h < 0) begin
          id_failed = 1'b1;
        end else if (nib_pend) begin
          nib_pend = 1'b0;
          emit_byte({hi_nib, 4'(h)});
        end else begin
          hi_nib = 4'(h);
          nib_pend = 1'b1;
        end
        if (fin && nib_pend) id_failed = 1'b1;
      end
    end
    if (fin) begin
      beats_due.push_back('{data: 8'h00, valid: 1'b0, done: 1'b1, status: id_failed});
      clear_id();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beats_due.delete();
      clear_id();
      cap_q = CapReset;
      errors = 0;
      beats_due_o <= 0;
      mismatches_o <= 0;
    end else begin
      if (psel && penable && pready && paddr == RegCapacity) begin
        if (pwrite) begin
          cap_q = pwdata[CapW-1:0];
        end else if (prdata !== {{(DataW-CapW){1'b0}}, cap_q}) begin
          note_mismatch("prdata", prdata, {{(DataW-CapW){1'b0}}, cap_q});
        end
      end
      if (s_axis_tvalid && s_axis_tready) decode_char(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (beats_due.size() == 0) begin
          note_mismatch("unexpected result beat, tdata", 32'(m_axis_tdata), 0);
        end else begin
          want = beats_due.pop_front();
          if (m_axis_tdata !== want.data) begin
            note_mismatch("out_byte", 32'(m_axis_tdata), 32'(want.data));
          end
          if (m_axis_tuser[0] !== want.valid) begin
            note_mismatch("byte_valid", 32'(m_axis_tuser[0]), 32'(want.valid));
          end
          if (m_axis_tuser[1] !== want.status) begin
            note_mismatch("status", 32'(m_axis_tuser[1]), 32'(want.status));
          end
          if (m_axis_tlast !== want.done) begin
            note_mismatch("done", 32'(m_axis_tlast), 32'(want.done));
          end
        end
      end
      beats_due_o <= beats_due.size();
      mismatches_o <= errors;
    end
  end

endmodule

[dv/rev_id_text_to_binary_test.sv]
// ----------------------------------------------------------------------------
// Revision ID converter testbench
// Feeds directed and random text revision IDs under several capacities, with
// random gaps and stalls on both streams, and takes the verdict from the
// checker that runs beside the block.
// ----------------------------------------------------------------------------
module rev_id_text_to_binary_test;
  import ritb_pkg::*;

  localparam int IdleLimit  = 3000;
  localparam int HoldCycles = 240;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;
  logic [1:0]       m_axis_tuser;
  logic             m_axis_tlast;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  int mismatches;
  int beats_due;
  int chars_sent = 0;
  int quiet_chars = 0;
  int hold_ask = 0;
  int idle_cycles = 0;
  bit send_gappy = 1'b1;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  rev_id_text_to_binary DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rev_id_text_to_binary_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .mismatches_o(mismatches), .beats_due_o(beats_due)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic fin);
    int gap;
    gap = (quiet_chars > 0 || !send_gappy) ? 0 : $urandom_range(0, 14);
    if (quiet_chars > 0) quiet_chars--;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    s_axis_tlast <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (beats_due != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [DataW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= RegCapacity;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'(CharZero + v);
    return 8'((($urandom_range(0, 1) != 0) ? CharUpA : CharLowA) + v - 10);
  endfunction

  // Mostly well-formed IDs with random content, some mangled, some pure noise.
  task automatic send_random_id(input int cap);
    logic [7:0] txt[$];
    int         nd;
    int         gen;
    int         vlen;
    int         nbytes;
    int         d;
    bit         zero_gen;
    send_gappy = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
    end else begin
      nd = ($urandom_range(0, 11) == 0) ? MaxGenDigits + 1 : $urandom_range(1, MaxGenDigits);
      zero_gen = ($urandom_range(0, 15) == 0);
      gen = 0;
      for (int i = 0; i < nd; i++) begin
        d = zero_gen ? 0 : $urandom_range(0, 9);
        gen = gen * 10 + d;
        txt.push_back(8'(CharZero + d));
      end
      txt.push_back(CharDash);
      vlen = (gen < 2**7) ? 1 : (gen < 2**14) ? 2 : (gen < 2**21) ? 3 : 4;
      if ($urandom_range(0, 9) == 0) begin
        nbytes = cap - vlen + $urandom_range(0, 1);
        if (nbytes < 0) nbytes = 0;
      end else begin
        nbytes = $urandom_range(1, 5);
      end
      repeat (2 * nbytes) txt.push_back(hex_char(4'($urandom_range(0, 15))));
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 5))
          0: txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
          1: txt.delete(nd);
          2: txt.push_back(hex_char(4'($urandom_range(0, 15))));
          3: while (txt.size() > nd + 1) void'(txt.pop_back());
          4: txt.insert($urandom_range(nd + 1, txt.size()), CharDash);
          default: txt[0] = CharDash;
        endcase
      end
    end
    foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
  endtask

  initial begin
    int stall;
    int hold_seen;
    bit take_gappy;
    hold_seen = 0;
    take_gappy = 1'b1;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      if ($urandom_range(0, 31) == 0) take_gappy = !take_gappy;
      stall = take_gappy ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid && hold_ask == hold_seen);
    end
  end

  initial begin
    int caps[5];
    int goal;
    bit paused;
    caps = '{64, 1, 4, 17, 42};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("99999999-fF");
    send_text("-");
    send_text("00-A9");
    send_text("7");
    send_text("5-");
    send_text("2-g");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);

    goal = chars_sent;
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      repeat (8) @(posedge clk_i);
      apb_access(1'b1, DataW'(caps[p]));
      apb_access(1'b0, '0);
      if (p == 0) begin
        hold_ask <= hold_ask + 1;
        quiet_chars = 40;
      end
      goal += 72;
      paused = 1'b0;
      while (chars_sent < goal) begin
        send_random_id(caps[p]);
        if (!paused && chars_sent >= goal - 36) begin
          paused = 1'b1;
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && beats_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ritb_pkg.sv
hw/rtl/ritb_front.sv
hw/rtl/ritb_queue.sv
hw/rtl/ritb_back.sv
hw/rtl/rev_id_text_to_binary.sv
dv/rev_id_text_to_binary_checker.sv
dv/rev_id_text_to_binary_test.sv
